// File: rtl/smpq_pkg.sv
// Shared types and constants for the sorted minimum priority queue.
package smpq_pkg;

  localparam int unsigned WeightW = 31;
  localparam int unsigned TagW    = 9;
  localparam int unsigned OccW    = 9;

  localparam logic CmdInsert = 1'b0;
  localparam logic CmdPop    = 1'b1;

  typedef enum logic [1:0] {
    StInserted = 2'd0,
    StPopped   = 2'd1,
    StEmptyPop = 2'd2,
    StFullDrop = 2'd3
  } status_e;

  typedef struct packed {
    logic [WeightW-1:0] weight;
    logic [TagW-1:0]    tag;
  } entry_t;

  typedef struct packed {
    logic               insert;
    logic               pop;
    logic [WeightW-1:0] weight;
    logic [TagW-1:0]    tag;
  } ctrl_t;

endpackage

// File: rtl/smpq_cell.sv
// One slot of the sorted chain: holds an entry and shifts it left or right on command.
module smpq_cell import smpq_pkg::*; (
  input  logic   clk_i,
  input  ctrl_t  ctrl_i,
  input  logic   occupied_i,
  input  logic   prev_ge_i,
  input  entry_t prev_entry_i,
  input  entry_t next_entry_i,
  output logic   ge_o,
  output entry_t entry_o
);

  entry_t entry_q, entry_d;

  // The new entry goes ahead of every held entry whose weight is not less than its own.
  assign ge_o = !occupied_i || (entry_q.weight >= ctrl_i.weight);

  always_comb begin
    entry_d = entry_q;
    priority if (ctrl_i.insert) begin
      if (ge_o) begin
        if (prev_ge_i) begin
          entry_d = prev_entry_i;
        end else begin
          entry_d.weight = ctrl_i.weight;
          entry_d.tag    = ctrl_i.tag;
        end
      end
    end else if (ctrl_i.pop) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// File: rtl/sorted_min_priority_queue.sv
// Top level of the sorted minimum priority queue built as a chain of shifting cells.
// The result strobe done_o rises in the cycle after the transfer of a command.
// Throughput: one insert or pop per cycle; every cell compares and shifts in that cycle.
// The receiver cannot stall, so busy stays low and a result is never held back.
// Reset clears the entry count and the result strobe; cell contents need no reset.
// Entries beyond the count are never read, so no clearing pass follows reset.
module sorted_min_priority_queue import smpq_pkg::*; #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cmd_i,
  input  logic [WeightW-1:0] key_weight_i,
  input  logic [TagW-1:0]    entry_tag_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [WeightW-1:0] popped_weight_o,
  output logic [TagW-1:0]    popped_tag_o,
  output logic [OccW-1:0]    occupancy_o,
  output logic               now_empty_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            done_q;
  status_e         status_q, status_d;
  entry_t          popped_q, popped_d;
  logic            empty_q;
  logic [OccW-1:0] occ_q;
  logic [CntW+OccW-1:0] count_ext;

  logic   accept, is_full, none_held;
  ctrl_t  ctrl;
  entry_t cell_entry [CAPACITY];
  logic [CAPACITY-1:0] cell_ge;
  logic [CAPACITY-1:0] occupied;

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign is_full   = (count_q == CntW'(CAPACITY));
  assign none_held = (count_q == '0);

  assign ctrl.insert = accept && (cmd_i == CmdInsert) && !is_full;
  assign ctrl.pop    = accept && (cmd_i == CmdPop) && !none_held;
  assign ctrl.weight = key_weight_i;
  assign ctrl.tag    = entry_tag_i;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    entry_t prev_entry, next_entry;
    logic   prev_ge;

    assign occupied[g] = (count_q > CntW'(g));

    if (g == 0) begin : g_first
      assign prev_entry = '0;
      assign prev_ge    = 1'b0;
    end else begin : g_mid
      assign prev_entry = cell_entry[g-1];
      assign prev_ge    = cell_ge[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign next_entry = '0;
    end else begin : g_inner
      assign next_entry = cell_entry[g+1];
    end

    smpq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occupied_i   (occupied[g]),
      .prev_ge_i    (prev_ge),
      .prev_entry_i (prev_entry),
      .next_entry_i (next_entry),
      .ge_o         (cell_ge[g]),
      .entry_o      (cell_entry[g])
    );
  end

  always_comb begin
    count_d  = count_q;
    popped_d = '0;
    status_d = StInserted;
    unique case (cmd_i)
      CmdInsert: begin
        if (is_full) begin
          status_d = StFullDrop;
        end else begin
          status_d = StInserted;
          count_d  = count_q + CntW'(1);
        end
      end
      CmdPop: begin
        if (none_held) begin
          status_d = StEmptyPop;
        end else begin
          status_d = StPopped;
          popped_d = cell_entry[0];
          count_d  = count_q - CntW'(1);
        end
      end
      default: status_d = StInserted;
    endcase
  end

  assign count_ext = {{OccW{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      popped_q <= popped_d;
      occ_q    <= count_ext[OccW-1:0];
      empty_q  <= (count_d == '0);
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign popped_weight_o = popped_q.weight;
  assign popped_tag_o    = popped_q.tag;
  assign occupancy_o     = occ_q;
  assign now_empty_o     = empty_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("Entry count exceeds the capacity.");

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("A command transfer produced no result strobe.");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o)
    else $error("A result strobe appeared without a command transfer.");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CntW'(2)) |-> (cell_entry[0].weight <= cell_entry[1].weight))
    else $error("The head entry is heavier than the entry behind it.");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_i == CmdInsert) && is_full) |=> (status_o == StFullDrop))
    else $error("An insert into a full queue was not reported as dropped.");

endmodule

// File: test/smpq_checker.sv
// Result checker for the sorted minimum priority queue: it mirrors the queue and compares every result.
module smpq_checker import smpq_pkg::*; #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic               cmd_i,
  input  logic [WeightW-1:0] key_weight_i,
  input  logic [TagW-1:0]    entry_tag_i,
  input  logic               done_o,
  input  logic [1:0]         status_o,
  input  logic [WeightW-1:0] popped_weight_o,
  input  logic [TagW-1:0]    popped_tag_o,
  input  logic [OccW-1:0]    occupancy_o,
  input  logic               now_empty_o,
  output int unsigned        outstanding_o,
  output int unsigned        fail_count_o
);

  typedef struct packed {
    status_e            status;
    logic [WeightW-1:0] weight;
    logic [TagW-1:0]    tag;
    logic [OccW-1:0]    occ;
    logic               empty;
  } outcome_t;

  entry_t      held_entries[$];
  outcome_t    awaited_q[$];
  outcome_t    want;
  int unsigned mismatches = 0;

  function automatic outcome_t queue_op(input logic cmd, input logic [WeightW-1:0] weight,
                                        input logic [TagW-1:0] tag);
    outcome_t    res;
    entry_t      e;
    int unsigned pos;
    res = '0;
    if (cmd == CmdInsert) begin
      if (held_entries.size() >= CAPACITY) begin
        res.status = StFullDrop;
      end else begin
        // The new entry goes ahead of every held entry of equal weight.
        pos = 0;
        while (pos < held_entries.size() && held_entries[pos].weight < weight) pos++;
        e.weight = weight;
        e.tag    = tag;
        held_entries.insert(pos, e);
        res.status = StInserted;
      end
    end else if (held_entries.size() == 0) begin
      res.status = StEmptyPop;
    end else begin
      e          = held_entries.pop_front();
      res.status = StPopped;
      res.weight = e.weight;
      res.tag    = e.tag;
    end
    res.occ   = OccW'(held_entries.size());
    res.empty = (held_entries.size() == 0);
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] expected,
                                      input logic [63:0] actual);
    if (expected !== actual) begin
      $error("%s: expected %0d, actual %0d", name, expected, actual);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (awaited_q.size() == 0) begin
          $error("result with no transfer outstanding");
          mismatches++;
        end else begin
          want = awaited_q.pop_front();
          check_field("status", want.status, status_o);
          check_field("popped_weight", want.weight, popped_weight_o);
          check_field("popped_tag", want.tag, popped_tag_o);
          check_field("occupancy", want.occ, occupancy_o);
          check_field("now_empty", want.empty, now_empty_o);
        end
      end
      if (start && !busy) awaited_q.push_back(queue_op(cmd_i, key_weight_i, entry_tag_i));
    end
    outstanding_o <= awaited_q.size();
    fail_count_o  <= mismatches;
  end

endmodule

// File: test/sorted_min_priority_queue_test.sv
// Testbench top for the sorted minimum priority queue: clock, reset, stimulus and verdict.
module sorted_min_priority_queue_test;
  import smpq_pkg::*;

  localparam int unsigned Capacity   = 256;
  localparam int unsigned Items      = 2000;
  localparam int unsigned StallLimit = 2000;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               cmd_i;
  logic [WeightW-1:0] key_weight_i;
  logic [TagW-1:0]    entry_tag_i;
  logic               done_o;
  logic [1:0]         status_o;
  logic [WeightW-1:0] popped_weight_o;
  logic [TagW-1:0]    popped_tag_o;
  logic [OccW-1:0]    occupancy_o;
  logic               now_empty_o;
  int unsigned        outstanding;
  int unsigned        fail_count;

  sorted_min_priority_queue #(.CAPACITY(Capacity)) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .cmd_i           (cmd_i),
    .key_weight_i    (key_weight_i),
    .entry_tag_i     (entry_tag_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .popped_weight_o (popped_weight_o),
    .popped_tag_o    (popped_tag_o),
    .occupancy_o     (occupancy_o),
    .now_empty_o     (now_empty_o)
  );

  smpq_checker #(.CAPACITY(Capacity)) order_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .cmd_i           (cmd_i),
    .key_weight_i    (key_weight_i),
    .entry_tag_i     (entry_tag_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .popped_weight_o (popped_weight_o),
    .popped_tag_o    (popped_tag_o),
    .occupancy_o     (occupancy_o),
    .now_empty_o     (now_empty_o),
    .outstanding_o   (outstanding),
    .fail_count_o    (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [WeightW-1:0] pick_weight();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3: return WeightW'($urandom_range(15));
      4: return WeightW'($urandom_range(1100, 1000));
      default: return WeightW'($urandom());
    endcase
  endfunction

  task automatic send_op(input logic cmd, input logic [WeightW-1:0] weight,
                         input logic [TagW-1:0] tag, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    cmd_i        <= cmd;
    key_weight_i <= weight;
    entry_tag_i  <= tag;
    start        <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (start && !busy) || done_o) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned mode;
    int unsigned seg_left;
    int unsigned idle_pct;
    int unsigned pop_pct;
    rst_ni       <= 1'b0;
    start        <= 1'b0;
    cmd_i        <= CmdInsert;
    key_weight_i <= '0;
    entry_tag_i  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_op(CmdPop, '1, '1, 9);
    send_op(CmdInsert, '1, '1, 9);
    send_op(CmdInsert, '0, '0, 9);
    send_op(CmdInsert, 31'h2AAA_AAAA, 9'h155, 9);
    send_op(CmdInsert, 31'h5555_5555, 9'h0AA, 9);
    send_op(CmdInsert, 31'd5, 9'd1, 9);
    send_op(CmdInsert, 31'd5, 9'd2, 9);
    send_op(CmdInsert, 31'd5, 9'd3, 9);
    send_op(CmdInsert, '0, 9'd7, 9);
    repeat (9) send_op(CmdPop, '0, '0, 9);

    // Segments lean toward filling, draining or an even mix, so the queue reaches full and empty.
    seg_left = 0;
    mode     = 0;
    for (int i = 0; i < Items; i++) begin
      if (seg_left == 0) begin
        mode     = $urandom_range(9);
        seg_left = $urandom_range(20, 350);
      end
      seg_left--;
      idle_pct = (i < Items / 3) ? 9 : (i < 2 * Items / 3) ? 80 : 0;
      pop_pct  = (mode < 4) ? 5 : (mode < 7) ? 95 : 50;
      send_op(($urandom_range(99) < pop_pct) ? CmdPop : CmdInsert, pick_weight(),
              TagW'($urandom_range(511)), idle_pct);
    end
    start <= 1'b0;

    do @(posedge clk_i); while (outstanding != 0);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
